>>> src/nads_pkg.sv
// nads_pkg: shared constants, types and helpers for the number to ascii streamer
// no dependencies
`default_nettype none

package nads_pkg;

   localparam int VALUE_W   = 64;
   localparam int OP_W      = 3;
   localparam int CHAR_W    = 8;
   localparam int BCD_DIGS  = 20;
   localparam int BCD_W     = 4 * BCD_DIGS;
   localparam int CNT_W     = 7;

   localparam logic [OP_W-1:0] OP_SDEC  = 3'd0;
   localparam logic [OP_W-1:0] OP_DEC4  = 3'd1;
   localparam logic [OP_W-1:0] OP_BIN   = 3'd2;
   localparam logic [OP_W-1:0] OP_BIN8  = 3'd3;
   localparam logic [OP_W-1:0] OP_HEX8  = 3'd4;
   localparam logic [OP_W-1:0] OP_HEX64 = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

   typedef struct packed {
      logic               start;
      logic [CNT_W-1:0]   iters;
      logic [VALUE_W-1:0] value;
   } dab_req_type;

   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } dab_rsp_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'b0, d};
      end else begin
         r = CHAR_ALPHA + {4'b0, d};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/nads_dabble.sv
// nads_dabble: iterative binary to bcd converter, one add-3 and shift step per cycle
// depends on nads_pkg
`default_nettype none

module nads_dabble
   import nads_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire dab_req_type req,
   output dab_rsp_type rsp
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BCD_W-1:0]   adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         bin_in  = req.value;
         bcd_in  = '0;
         cnt_in  = req.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign rsp.done = done_ff;
   assign rsp.bcd  = bcd_ff;

endmodule

`default_nettype wire

>>> src/number_to_ascii_digit_streamer_top.sv
// number_to_ascii_digit_streamer_top: sequencer and character emitter
// depends on nads_pkg and nads_dabble
`default_nettype none

// sequencing: decimal modes run the shared bcd unit for 64 steps (signed) or 16 (four-digit),
//   signed decimal then skips leading zeros at one digit a cycle, and each character is sent
//   as one beat per cycle while rsp_tready is high
// overlap: one number at a time; no new number is taken until the last character is sent
// reset: synchronous, returns the sequencer to idle; the shift register is not cleared

module number_to_ascii_digit_streamer_top
   import nads_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [VALUE_W-1:0] req_tdata,   // value
   input  wire logic [OP_W-1:0]    req_tuser,   // operation
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [CHAR_W-1:0]  rsp_tdata,   // character
   output      logic               rsp_tlast    // last
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [BCD_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             wide_ff, wide_in;
   logic             skip_ff, skip_in;
   logic             minus_ff, minus_in;
   logic             short_ff, short_in;

   dab_req_type dab_req;
   dab_rsp_type dab_rsp;

   logic [3:0]         top_dig;
   logic [VALUE_W-1:0] mag;
   logic               in_beat, out_beat;

   nads_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .req   (dab_req),
      .rsp   (dab_rsp)
   );

   assign top_dig  = wide_ff ? sh_ff[BCD_W-1 -: 4] : {3'b0, sh_ff[BCD_W-1]};
   assign mag      = req_tdata[VALUE_W-1] ? (~req_tdata + 64'd1) : req_tdata;
   assign in_beat  = req_tvalid && req_tready;
   assign out_beat = rsp_tvalid && rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_tdata  = (state_ff == ST_SIGN) ? CHAR_MINUS : digit_char(top_dig);
   assign rsp_tlast  = (state_ff == ST_EMIT) && (cnt_ff == 7'd1);

   always_comb begin
      state_in      = state_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      wide_in       = wide_ff;
      skip_in       = skip_ff;
      minus_in      = minus_ff;
      short_in      = short_ff;
      dab_req.start = 1'b0;
      dab_req.iters = 7'd64;
      dab_req.value = mag;
      case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               minus_in = 1'b0;
               short_in = 1'b0;
               case (req_tuser)
                  OP_SDEC: begin
                     dab_req.start = 1'b1;
                     minus_in      = req_tdata[VALUE_W-1];
                     wide_in       = 1'b1;
                     skip_in       = 1'b1;
                     cnt_in        = 7'd20;
                     state_in      = ST_CONV;
                  end
                  OP_DEC4: begin
                     dab_req.start = 1'b1;
                     dab_req.iters = 7'd16;
                     dab_req.value = {req_tdata[15:0], 48'b0};
                     short_in      = 1'b1;
                     wide_in       = 1'b1;
                     skip_in       = 1'b0;
                     cnt_in        = 7'd4;
                     state_in      = ST_CONV;
                  end
                  OP_BIN: begin
                     sh_in    = {req_tdata, 16'b0};
                     wide_in  = 1'b0;
                     cnt_in   = 7'd64;
                     state_in = ST_SKIP;
                  end
                  OP_BIN8: begin
                     sh_in    = {req_tdata[7:0], 72'b0};
                     wide_in  = 1'b0;
                     cnt_in   = 7'd8;
                     state_in = ST_EMIT;
                  end
                  OP_HEX8: begin
                     sh_in    = {req_tdata[7:0], 72'b0};
                     wide_in  = 1'b1;
                     cnt_in   = 7'd2;
                     state_in = ST_EMIT;
                  end
                  OP_HEX64: begin
                     sh_in    = {req_tdata, 16'b0};
                     wide_in  = 1'b1;
                     cnt_in   = 7'd16;
                     state_in = ST_SKIP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            if (dab_rsp.done) begin
               sh_in = short_ff ? {dab_rsp.bcd[15:0], 64'b0} : dab_rsp.bcd;
               if (minus_ff) begin
                  state_in = ST_SIGN;
               end else if (skip_ff) begin
                  state_in = ST_SKIP;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_beat) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_dig == 4'd0) && (cnt_ff > 7'd1)) begin
               sh_in  = wide_ff ? (sh_ff << 4) : (sh_ff << 1);
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_beat) begin
               sh_in  = wide_ff ? (sh_ff << 4) : (sh_ff << 1);
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         minus_ff <= 1'b0;
         short_ff <= 1'b0;
         skip_ff  <= 1'b0;
         wide_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         minus_ff <= minus_in;
         short_ff <= short_in;
         skip_ff  <= skip_in;
         wide_ff  <= wide_in;
      end
      sh_ff <= sh_in;
   end

   // no new number while characters are still going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while sending characters");

   // the final beat returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not idle after last beat");

   // bcd unit finishes only while the sequencer waits for it
   a_done_conv: assert property (@(posedge clock) disable iff (reset)
      dab_rsp.done |-> (state_ff == ST_CONV))
      else $error("bcd done outside conversion");

endmodule

`default_nettype wire
